[rtl/core/kalman_point_tracker_core_macros.svh]
// ----------------------------------------------------------------------------
// kalman point tracker assertion macros
// short forms for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef KALMAN_POINT_TRACKER_CORE_MACROS_SVH
`define KALMAN_POINT_TRACKER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KPT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpt check failed");

// next-cycle implication, disabled in reset
`define KPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpt check failed");

`endif

[rtl/core/kpt_pkg.sv]
// ----------------------------------------------------------------------------
// kpt_pkg
// shared types, constants and helpers of the point tracker core
// ----------------------------------------------------------------------------
`default_nettype none

package kpt_pkg;

  localparam int POS_FRAC_BITS_DEF = 8;
  localparam int COV_FRAC_BITS_DEF = 24;

  localparam int MEAS_W  = 12;
  localparam int POS_W   = 21;
  localparam int SPD_W   = 19;
  localparam int REG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int NOISE_W = 24;
  localparam int CNT_W   = 8;
  localparam int UOP_W   = 6;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 24'd16777;
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 24'd167772;
  localparam logic [REG_W-1:0]   INIT_COV_RST          = 32'd1677722;
  localparam logic [CNT_W-1:0]   MAX_LOST_RST          = 8'd15;

  localparam logic signed [31:0] LIM32 = 32'sh7fff_ffff;

  // last step of the correction program
  localparam logic [UOP_W-1:0] UOP_LAST = 6'd57;

  typedef enum logic [IDX_W-1:0] {
    REG_PROCESS_NOISE     = 3'd0,
    REG_MEASUREMENT_NOISE = 3'd1,
    REG_INIT_COV          = 3'd2,
    REG_MAX_LOST          = 3'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_PRED, ST_MISS, ST_SETUP,
    ST_MUL, ST_ACC, ST_STORE, ST_DIVW, ST_FIN
  } state_t;

  typedef enum logic [1:0] {OPA_S, OPA_P, OPA_K} opa_t;
  typedef enum logic [1:0] {OPB_S, OPB_Y, OPB_OLD} opb_t;
  typedef enum logic [2:0] {DST_NONE, DST_DET, DST_GAIN, DST_EST, DST_COV} dst_t;

  typedef struct packed {
    opa_t       opa;
    logic [3:0] a_idx;
    opb_t       opb;
    logic [2:0] b_idx;
    logic       first;
    logic       sub;
    dst_t       dst;
    logic [3:0] d_idx;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic seed;
    logic predict;
    logic miss;
    logic setup;
    logic mul;
    logic acc;
    logic store;
    logic div_wr;
    logic out_load;
    uop_t uop;
  } kpt_cmd_t;

  typedef struct packed {
    logic active;
    logic found;
    logic det_zero;
    logic div_done;
  } kpt_sts_t;

  // decode of one multiply-accumulate step of the correction
  function automatic uop_t uop_decode(input logic [UOP_W-1:0] n);
    logic [UOP_W-1:0] t;
    logic             odd;
    logic             second;
    uop_t             u;
    u        = '0;
    t        = '0;
    odd      = 1'b0;
    second   = n[0];
    u.first  = ~n[0];
    u.dst    = DST_NONE;
    if (n < 6'd2) begin
      // determinant of the innovation covariance
      u.opa = OPA_S;
      u.opb = OPB_S;
      if (!second) begin
        u.a_idx = 4'd0;
        u.b_idx = 3'd3;
      end else begin
        u.a_idx = 4'd1;
        u.b_idx = 3'd2;
        u.sub   = 1'b1;
        u.dst   = DST_DET;
      end
    end else if (n < 6'd18) begin
      // gain numerators, row i, column odd
      t       = n - 6'd2;
      odd     = t[1];
      u.opa   = OPA_P;
      u.opb   = OPB_S;
      u.a_idx = {t[3:2], 1'b0, odd ^ second};
      u.b_idx = {1'b0, ~odd, ~odd ^ second};
      if (second) begin
        u.sub   = 1'b1;
        u.dst   = DST_GAIN;
        u.d_idx = {1'b0, t[3:1]};
      end
    end else if (n < 6'd26) begin
      t       = n - 6'd18;
      u.opa   = OPA_K;
      u.opb   = OPB_Y;
      u.a_idx = {1'b0, t[2:1], t[0]};
      u.b_idx = {2'b00, t[0]};
      if (second) begin
        u.dst   = DST_EST;
        u.d_idx = {2'b00, t[2:1]};
      end
    end else begin
      t       = n - 6'd26;
      u.opa   = OPA_K;
      u.opb   = OPB_OLD;
      u.a_idx = {1'b0, t[4:3], t[0]};
      u.b_idx = {t[0], t[2:1]};
      if (second) begin
        u.dst   = DST_COV;
        u.d_idx = t[4:1];
      end
    end
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    hi = 64'(LIM32);
    if (v > hi) begin
      return LIM32;
    end else if (v < -hi) begin
      return -LIM32;
    end
    return v[31:0];
  endfunction

  // unsigned register value with 24 fraction bits to frac fraction bits
  function automatic logic signed [31:0] to_cov(input logic [31:0] v, input int frac);
    logic [63:0] w;
    if (frac >= 24) begin
      w = {32'd0, v} << (frac - 24);
    end else begin
      w = {32'd0, v} >> (24 - frac);
    end
    if (w > 64'(LIM32)) begin
      return LIM32;
    end
    return w[31:0];
  endfunction

  function automatic logic [POS_W-1:0] fit_pos(input logic signed [31:0] v);
    if (v > 32'sd1048575) begin
      return 21'h0f_ffff;
    end else if (v < -32'sd1048576) begin
      return 21'h10_0000;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic [SPD_W-1:0] fit_spd(input logic signed [31:0] v);
    if (v > 32'sd262143) begin
      return 19'h3_ffff;
    end else if (v < -32'sd262144) begin
      return 19'h4_0000;
    end
    return v[SPD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/kpt_if.sv]
// ----------------------------------------------------------------------------
// kpt channels
// measurement and track channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface kpt_meas_if;
  logic                       valid;
  logic                       ready;
  logic [kpt_pkg::MEAS_W-1:0] measured_x;
  logic [kpt_pkg::MEAS_W-1:0] measured_y;
  logic                       found;

  modport source (output valid, output measured_x, output measured_y, output found,
                  input ready);
  modport sink (input valid, input measured_x, input measured_y, input found,
                output ready);
endinterface

interface kpt_track_if;
  logic                      valid;
  logic                      ready;
  logic [kpt_pkg::POS_W-1:0] position_x;
  logic [kpt_pkg::POS_W-1:0] position_y;
  logic [kpt_pkg::SPD_W-1:0] speed_x;
  logic [kpt_pkg::SPD_W-1:0] speed_y;
  logic                      tracking;

  modport source (output valid, output position_x, output position_y, output speed_x,
                  output speed_y, output tracking, input ready);
  modport sink (input valid, input position_x, input position_y, input speed_x,
                input speed_y, input tracking, output ready);
endinterface

`default_nettype wire

[rtl/core/kpt_div.sv]
// ----------------------------------------------------------------------------
// kpt_div
// gain divider: num * 2^F / den, truncated, saturated, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kpt_div #(
  parameter int COV_FRAC_BITS = kpt_pkg::COV_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [63:0] den,
  output logic                    done,
  output logic signed [31:0]      q
);

  localparam int PRE = 31 - COV_FRAC_BITS;

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] ud;
  logic [30:0] nl;
  logic [30:0] qb;
  logic        neg;

  logic [63:0] un_in;
  logic [63:0] ud_in;
  logic [95:0] nshift;
  logic        ovf;
  logic [64:0] rs;
  logic        ge;

  always_comb begin
    un_in  = num[63] ? 64'(-num) : 64'(num);
    ud_in  = den[63] ? 64'(-den) : 64'(den);
    nshift = {32'd0, un_in} << COV_FRAC_BITS;
    // quotient reaches 2^31 exactly when num >= den * 2^(31-F)
    ovf    = {32'd0, un_in} >= ({32'd0, ud_in} << PRE);
    rs     = {rem, nl[30]};
    ge     = rs >= {1'b0, ud};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[63] ^ den[63];
        ud  <= ud_in;
        cnt <= '0;
        if (ovf) begin
          qb   <= '1;
          done <= 1'b1;
        end else begin
          rem  <= nshift[94:31];
          nl   <= nshift[30:0];
          qb   <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (ge) begin
          rem <= 64'(rs - {1'b0, ud});
        end else begin
          rem <= rs[63:0];
        end
        qb  <= {qb[29:0], ge};
        nl  <= {nl[29:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q = neg ? -$signed({1'b0, qb}) : $signed({1'b0, qb});

endmodule

`default_nettype wire

[rtl/core/kpt_datapath.sv]
// ----------------------------------------------------------------------------
// kpt_datapath
// filter state, shared multiplier, accumulator and divider
// ----------------------------------------------------------------------------
`default_nettype none

module kpt_datapath #(
  parameter int POS_FRAC_BITS = kpt_pkg::POS_FRAC_BITS_DEF,
  parameter int COV_FRAC_BITS = kpt_pkg::COV_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire kpt_pkg::kpt_cmd_t           cmd,
  output kpt_pkg::kpt_sts_t                sts,
  input  wire logic [kpt_pkg::MEAS_W-1:0]  measured_x,
  input  wire logic [kpt_pkg::MEAS_W-1:0]  measured_y,
  input  wire logic                        found_in,
  input  wire logic                        wr_en,
  input  wire logic [kpt_pkg::IDX_W-1:0]   wr_index,
  input  wire logic [kpt_pkg::REG_W-1:0]   wr_data,
  output logic [kpt_pkg::POS_W-1:0]        position_x,
  output logic [kpt_pkg::POS_W-1:0]        position_y,
  output logic [kpt_pkg::SPD_W-1:0]        speed_x,
  output logic [kpt_pkg::SPD_W-1:0]        speed_y,
  output logic                             tracking
);

  logic [kpt_pkg::NOISE_W-1:0] process_noise;
  logic [kpt_pkg::NOISE_W-1:0] measurement_noise;
  logic [kpt_pkg::REG_W-1:0]   init_cov;
  logic [kpt_pkg::CNT_W-1:0]   max_lost;

  logic signed [31:0] est [4];
  logic signed [31:0] cov [16];
  logic signed [31:0] cov_pred [16];
  logic signed [31:0] old0 [8];
  logic signed [31:0] k [8];
  logic signed [31:0] s [4];
  logic signed [31:0] y [2];
  logic signed [31:0] zx;
  logic signed [31:0] zy;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] det;
  logic               found;
  logic               active;
  logic               echo;
  logic [kpt_pkg::CNT_W-1:0] lost_count;

  logic signed [31:0] q_cov;
  logic signed [31:0] r_cov;
  logic signed [31:0] diag_new;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] term;
  logic signed [63:0] acc_rnd;
  logic [8:0]         lost_inc;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic               reload;

  // divide by 2^F rounding half away from zero
  function automatic logic signed [63:0] rround(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + (64'd1 << (COV_FRAC_BITS - 1))) >> COV_FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  assign q_cov    = kpt_pkg::to_cov({8'd0, process_noise}, COV_FRAC_BITS);
  assign r_cov    = kpt_pkg::to_cov({8'd0, measurement_noise}, COV_FRAC_BITS);
  assign diag_new = kpt_pkg::to_cov(wr_data, COV_FRAC_BITS);
  assign reload   = wr_en && (wr_index == kpt_pkg::REG_INIT_COV);
  assign acc_rnd  = rround(acc);
  assign lost_inc = {1'b0, lost_count} + 9'd1;

  // P <- F P F^T + Q, all sixteen entries side by side
  always_comb begin
    logic signed [35:0] a0;
    logic signed [35:0] a1;
    logic signed [35:0] sum;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        a0 = 36'(cov[i*4+j]);
        if (i < 2) a0 = a0 + 36'(cov[(i+2)*4+j]);
        a1 = '0;
        if (j < 2) begin
          a1 = 36'(cov[i*4+j+2]);
          if (i < 2) a1 = a1 + 36'(cov[(i+2)*4+j+2]);
        end
        sum = a0 + a1;
        if (i == j) sum = sum + 36'(q_cov);
        cov_pred[i*4+j] = kpt_pkg::sat32(64'(sum));
      end
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (cmd.uop.opa)
      kpt_pkg::OPA_S: op_a = s[cmd.uop.a_idx[1:0]];
      kpt_pkg::OPA_P: op_a = cov[cmd.uop.a_idx];
      kpt_pkg::OPA_K: op_a = k[cmd.uop.a_idx[2:0]];
      default:        op_a = '0;
    endcase
    unique case (cmd.uop.opb)
      kpt_pkg::OPB_S:   op_b = s[cmd.uop.b_idx[1:0]];
      kpt_pkg::OPB_Y:   op_b = y[cmd.uop.b_idx[0]];
      kpt_pkg::OPB_OLD: op_b = old0[cmd.uop.b_idx];
      default:          op_b = '0;
    endcase
    term = cmd.uop.sub ? -prod : prod;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= kpt_pkg::PROCESS_NOISE_RST;
      measurement_noise <= kpt_pkg::MEASUREMENT_NOISE_RST;
      init_cov          <= kpt_pkg::INIT_COV_RST;
      max_lost          <= kpt_pkg::MAX_LOST_RST;
    end else if (wr_en) begin
      unique case (kpt_pkg::reg_idx_t'(wr_index))
        kpt_pkg::REG_PROCESS_NOISE:     process_noise     <= wr_data[kpt_pkg::NOISE_W-1:0];
        kpt_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= wr_data[kpt_pkg::NOISE_W-1:0];
        kpt_pkg::REG_INIT_COV:          init_cov          <= wr_data;
        kpt_pkg::REG_MAX_LOST:          max_lost          <= wr_data[kpt_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // covariance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        cov[i] <= (i % 5 == 0) ? kpt_pkg::to_cov(kpt_pkg::INIT_COV_RST, COV_FRAC_BITS) : '0;
      end
    end else if (reload) begin
      for (int i = 0; i < 16; i++) begin
        cov[i] <= (i % 5 == 0) ? diag_new : '0;
      end
    end else if (cmd.predict) begin
      cov <= cov_pred;
    end else if (cmd.store && cmd.uop.dst == kpt_pkg::DST_COV) begin
      cov[cmd.uop.d_idx] <= kpt_pkg::sat32(64'(cov[cmd.uop.d_idx]) - acc_rnd);
    end
  end

  // estimate and track status
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) est[i] <= '0;
      active     <= 1'b0;
      lost_count <= '0;
    end else begin
      if (cmd.seed && found) begin
        est[0]     <= zx;
        est[1]     <= zy;
        est[2]     <= '0;
        est[3]     <= '0;
        active     <= 1'b1;
        lost_count <= '0;
      end
      if (cmd.predict) begin
        est[0] <= kpt_pkg::sat32(64'(est[0]) + 64'(est[2]));
        est[1] <= kpt_pkg::sat32(64'(est[1]) + 64'(est[3]));
      end
      if (cmd.setup) lost_count <= '0;
      if (cmd.miss) begin
        if (lost_inc > {1'b0, max_lost}) active <= 1'b0;
        lost_count <= lost_inc[8] ? 8'hff : lost_inc[7:0];
      end
      if (cmd.store && cmd.uop.dst == kpt_pkg::DST_EST) begin
        est[cmd.uop.d_idx[1:0]] <= kpt_pkg::sat32(64'(est[cmd.uop.d_idx[1:0]]) + acc_rnd);
      end
    end
  end

  // working registers of one frame
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      zx    <= $signed(32'(measured_x) << POS_FRAC_BITS);
      zy    <= $signed(32'(measured_y) << POS_FRAC_BITS);
      found <= found_in;
    end
    if (cmd.seed) echo <= 1'b1;
    if (cmd.predict) echo <= 1'b0;
    if (cmd.setup) begin
      // innovation covariance H P H^T + R and a copy of the top two rows
      s[0] <= kpt_pkg::sat32(64'(cov[0]) + 64'(r_cov));
      s[1] <= cov[1];
      s[2] <= cov[4];
      s[3] <= kpt_pkg::sat32(64'(cov[5]) + 64'(r_cov));
      for (int i = 0; i < 8; i++) old0[i] <= cov[i];
      y[0] <= kpt_pkg::sat32(64'(zx) - 64'(est[0]));
      y[1] <= kpt_pkg::sat32(64'(zy) - 64'(est[1]));
    end
    if (cmd.mul) prod <= op_a * op_b;
    if (cmd.acc) acc <= cmd.uop.first ? term : acc + term;
    if (cmd.store && cmd.uop.dst == kpt_pkg::DST_DET) det <= acc;
    if (cmd.div_wr) k[cmd.uop.d_idx[2:0]] <= div_q;
    if (cmd.out_load) begin
      position_x <= kpt_pkg::fit_pos(echo ? zx : est[0]);
      position_y <= kpt_pkg::fit_pos(echo ? zy : est[1]);
      speed_x    <= echo ? '0 : kpt_pkg::fit_spd(est[2]);
      speed_y    <= echo ? '0 : kpt_pkg::fit_spd(est[3]);
      tracking   <= active && (lost_count < max_lost);
    end
  end

  assign div_start = cmd.store && (cmd.uop.dst == kpt_pkg::DST_GAIN);

  kpt_div #(
    .COV_FRAC_BITS(COV_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (acc),
    .den  (det),
    .done (div_done),
    .q    (div_q)
  );

  always_comb begin
    sts.active   = active;
    sts.found    = found;
    sts.det_zero = (acc == '0);
    sts.div_done = div_done;
  end

endmodule

`default_nettype wire

[rtl/core/kpt_ctrl.sv]
// ----------------------------------------------------------------------------
// kpt_ctrl
// frame sequencer: seed, predict, miss, correction program, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module kpt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              meas_valid,
  output logic                   meas_ready,
  output logic                   track_valid,
  input  wire logic              track_ready,
  input  wire kpt_pkg::kpt_sts_t sts,
  output kpt_pkg::kpt_cmd_t      cmd
);

  kpt_pkg::state_t                state;
  kpt_pkg::state_t                state_next;
  logic [kpt_pkg::UOP_W-1:0]      uop_idx;
  logic [kpt_pkg::UOP_W-1:0]      uop_idx_next;
  kpt_pkg::uop_t                  uop;
  logic                           slot_free;

  assign uop       = kpt_pkg::uop_decode(uop_idx);
  assign slot_free = !track_valid || track_ready;

  always_comb begin
    state_next   = state;
    uop_idx_next = uop_idx;
    unique case (state)
      kpt_pkg::ST_IDLE: begin
        if (meas_valid) state_next = sts.active ? kpt_pkg::ST_PRED : kpt_pkg::ST_SEED;
      end
      kpt_pkg::ST_SEED: state_next = kpt_pkg::ST_FIN;
      kpt_pkg::ST_PRED: state_next = sts.found ? kpt_pkg::ST_SETUP : kpt_pkg::ST_MISS;
      kpt_pkg::ST_MISS: state_next = kpt_pkg::ST_FIN;
      kpt_pkg::ST_SETUP: begin
        state_next   = kpt_pkg::ST_MUL;
        uop_idx_next = '0;
      end
      kpt_pkg::ST_MUL: state_next = kpt_pkg::ST_ACC;
      kpt_pkg::ST_ACC: begin
        if (uop.dst == kpt_pkg::DST_NONE) begin
          state_next   = kpt_pkg::ST_MUL;
          uop_idx_next = uop_idx + 6'd1;
        end else begin
          state_next = kpt_pkg::ST_STORE;
        end
      end
      kpt_pkg::ST_STORE: begin
        priority if (uop.dst == kpt_pkg::DST_GAIN) begin
          state_next = kpt_pkg::ST_DIVW;
        end else if (uop.dst == kpt_pkg::DST_DET && sts.det_zero) begin
          state_next = kpt_pkg::ST_FIN;
        end else if (uop_idx == kpt_pkg::UOP_LAST) begin
          state_next = kpt_pkg::ST_FIN;
        end else begin
          state_next   = kpt_pkg::ST_MUL;
          uop_idx_next = uop_idx + 6'd1;
        end
      end
      kpt_pkg::ST_DIVW: begin
        if (sts.div_done) begin
          state_next   = kpt_pkg::ST_MUL;
          uop_idx_next = uop_idx + 6'd1;
        end
      end
      kpt_pkg::ST_FIN: begin
        if (slot_free) state_next = kpt_pkg::ST_IDLE;
      end
      default: state_next = kpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    meas_ready   = (state == kpt_pkg::ST_IDLE);
    cmd          = '0;
    cmd.uop      = uop;
    cmd.capture  = (state == kpt_pkg::ST_IDLE) && meas_valid;
    cmd.seed     = (state == kpt_pkg::ST_SEED);
    cmd.predict  = (state == kpt_pkg::ST_PRED);
    cmd.miss     = (state == kpt_pkg::ST_MISS);
    cmd.setup    = (state == kpt_pkg::ST_SETUP);
    cmd.mul      = (state == kpt_pkg::ST_MUL);
    cmd.acc      = (state == kpt_pkg::ST_ACC);
    cmd.store    = (state == kpt_pkg::ST_STORE);
    cmd.div_wr   = (state == kpt_pkg::ST_DIVW) && sts.div_done;
    cmd.out_load = (state == kpt_pkg::ST_FIN) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kpt_pkg::ST_IDLE;
      uop_idx     <= '0;
      track_valid <= 1'b0;
    end else begin
      state   <= state_next;
      uop_idx <= uop_idx_next;
      if (cmd.out_load) begin
        track_valid <= 1'b1;
      end else if (track_ready) begin
        track_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/kalman_point_tracker_core.sv]
// ----------------------------------------------------------------------------
// kalman_point_tracker_core
// constant-velocity kalman filter on a 2-d point, fixed point, one frame a word
// ----------------------------------------------------------------------------
//
//  channel  | dir  | word contents
//  ---------+------+-------------------------------------------------------
//  meas     | sink | measured_x, measured_y (whole pixels), found
//  track    | src  | position_x/_y (q.8), speed_x/_y (q.8 per frame), tracking
//  wr_*     | in   | register index 0..3 and 32-bit data, written on wr_en
//
//  idle frame or seed: the word passes the seed and finish states to the output register
//  miss while tracking: the predict, miss and finish states
//  found while tracking: the time is set by the eight gain divisions (a saturating
//  gain ends its division early) and 58 multiply-accumulate steps on one multiplier
//  a result waits in the output register; the next word is taken meanwhile
//  reset is synchronous; it loads the register defaults and the covariance and clears the track
//
`default_nettype none

module kalman_point_tracker_core #(
  parameter int POS_FRAC_BITS = kpt_pkg::POS_FRAC_BITS_DEF,
  parameter int COV_FRAC_BITS = kpt_pkg::COV_FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  kpt_meas_if.sink                       meas,
  kpt_track_if.source                    track,
  input  wire logic                      wr_en,
  input  wire logic [kpt_pkg::IDX_W-1:0] wr_index,
  input  wire logic [kpt_pkg::REG_W-1:0] wr_data
);

  // command and status between sequencer and datapath
  kpt_pkg::kpt_cmd_t cmd;
  kpt_pkg::kpt_sts_t sts;

  logic meas_ready;
  logic track_valid;

  kpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas.valid),
    .meas_ready (meas_ready),
    .track_valid(track_valid),
    .track_ready(track.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // filter state and arithmetic
  kpt_datapath #(
    .POS_FRAC_BITS(POS_FRAC_BITS),
    .COV_FRAC_BITS(COV_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .measured_x(meas.measured_x),
    .measured_y(meas.measured_y),
    .found_in  (meas.found),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .position_x(track.position_x),
    .position_y(track.position_y),
    .speed_x   (track.speed_x),
    .speed_y   (track.speed_y),
    .tracking  (track.tracking)
  );

  assign meas.ready  = meas_ready;
  assign track.valid = track_valid;

`include "kalman_point_tracker_core_macros.svh"

  // one frame at a time: no second word right after an accept
  `KPT_ASSERT_NEXT(a_one_frame, clk, rst, meas.valid && meas_ready, !meas_ready)
  // the output register is only loaded when its word has gone
  `KPT_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !track_valid || track.ready)
  // seeding only happens while no track is held
  `KPT_ASSERT_IMP(a_seed_idle, clk, rst, cmd.seed, !sts.active)

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// point tracker core testbench
// drives frames of measured points through the core under changing noise and
// loss settings, mirrors the fixed-point filter in a local tracker model and
// compares every track word with the model's forecast
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam longint SAT_LIM    = 64'sd2147483647;
  localparam int     FRAC_COV   = 24;
  localparam int     FRAC_POS   = 8;
  localparam int     QUIET_LIM  = 40000;   // cycles without any word moving
  localparam int     TAIL_WAIT  = 16;      // idle clocks after the queues have drained
  localparam logic [kpt_pkg::IDX_W-1:0] FIRST_SPARE_IDX = 3'd4;

  typedef struct {
    logic [kpt_pkg::MEAS_W-1:0] x;
    logic [kpt_pkg::MEAS_W-1:0] y;
    logic                       found;
  } frame_t;

  typedef struct {
    logic [kpt_pkg::POS_W-1:0] px;
    logic [kpt_pkg::POS_W-1:0] py;
    logic [kpt_pkg::SPD_W-1:0] vx;
    logic [kpt_pkg::SPD_W-1:0] vy;
    logic                      trk;
  } track_word_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [kpt_pkg::IDX_W-1:0] wr_index;
  logic [kpt_pkg::REG_W-1:0] wr_data;

  kpt_meas_if  meas_ch();
  kpt_track_if track_ch();

  kalman_point_tracker_core dut (
    .clk      (clk),
    .rst      (rst),
    .meas     (meas_ch),
    .track    (track_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // frames waiting for the driver, and track words the model has forecast
  frame_t      frame_queue[$];
  track_word_t track_forecast[$];

  int err_count;
  int gap_pct;     // chance in a hundred that the sender idles a cycle
  int stall_pct;   // chance in a hundred that the receiver stalls a cycle
  int quiet_cycles;

  // local tracker model state
  logic [23:0] m_proc_noise;
  logic [23:0] m_meas_noise;
  logic [31:0] m_init_cov;
  logic [7:0]  m_max_lost;
  longint      m_est[4];
  longint      m_cov[16];
  bit          m_active;
  int          m_lost;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point helpers of the tracker model
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
  endfunction

  // divide by 2^24, rounding half away from zero
  function automatic longint round_shift(longint v);
    longint unsigned m;
    m = (magnitude(v) + (64'd1 << (FRAC_COV - 1))) >> FRAC_COV;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  // register value (24 fraction bits) to the covariance format
  function automatic longint reg_to_cov(logic [31:0] v);
    longint unsigned u;
    u = v;
    if (u > SAT_LIM) return SAT_LIM;
    return longint'(u);
  endfunction

  // num * 2^24 / den, truncated toward zero, saturated
  function automatic longint gain_quotient(longint num, longint den);
    longint unsigned un, ud, q, r;
    bit neg;
    int i;
    un  = magnitude(num);
    ud  = magnitude(den);
    q   = un / ud;
    r   = un % ud;
    neg = (num < 0) != (den < 0);
    if (q > SAT_LIM) q = SAT_LIM + 1;
    for (i = 0; i < FRAC_COV && q <= SAT_LIM; i++) begin
      r = r << 1;
      if (r >= ud) begin
        q = (q << 1) | 64'd1;
        r = r - ud;
      end else begin
        q = q << 1;
      end
    end
    if (q > SAT_LIM) q = SAT_LIM;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fit_field(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v;
  endfunction

  function automatic void reload_cov();
    longint d;
    d = reg_to_cov(m_init_cov);
    foreach (m_cov[i]) m_cov[i] = 0;
    for (int i = 0; i < 4; i++) m_cov[i * 5] = d;
  endfunction

  function automatic void tracker_reset();
    m_proc_noise = kpt_pkg::PROCESS_NOISE_RST;
    m_meas_noise = kpt_pkg::MEASUREMENT_NOISE_RST;
    m_init_cov   = kpt_pkg::INIT_COV_RST;
    m_max_lost   = kpt_pkg::MAX_LOST_RST;
    foreach (m_est[i]) m_est[i] = 0;
    reload_cov();
    m_active = 0;
    m_lost   = 0;
  endfunction

  // constant-velocity prediction of state and covariance
  function automatic void tracker_predict();
    longint a[16];
    longint q;
    q = reg_to_cov({8'd0, m_proc_noise});
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        a[i*4+j] = m_cov[i*4+j] + (i < 2 ? m_cov[(i+2)*4+j] : 0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m_cov[i*4+j] = clamp32(a[i*4+j] + (j < 2 ? a[i*4+j+2] : 0) + (i == j ? q : 0));
    m_est[0] = clamp32(m_est[0] + m_est[2]);
    m_est[1] = clamp32(m_est[1] + m_est[3]);
  endfunction

  // measurement update; a singular innovation leaves everything unchanged
  function automatic void tracker_correct(longint zx, longint zy);
    longint r, s00, s01, s10, s11, det, y0, y1, p0, p1;
    longint k[8];
    longint prev[16];
    r   = reg_to_cov({8'd0, m_meas_noise});
    s00 = clamp32(m_cov[0] + r);
    s01 = m_cov[1];
    s10 = m_cov[4];
    s11 = clamp32(m_cov[5] + r);
    det = s00 * s11 - s01 * s10;
    if (det == 0) return;
    for (int i = 0; i < 4; i++) begin
      p0 = m_cov[i*4];
      p1 = m_cov[i*4+1];
      k[i*2]   = gain_quotient(p0 * s11 - p1 * s10, det);
      k[i*2+1] = gain_quotient(p1 * s00 - p0 * s01, det);
    end
    y0 = clamp32(zx - m_est[0]);
    y1 = clamp32(zy - m_est[1]);
    for (int i = 0; i < 4; i++)
      m_est[i] = clamp32(m_est[i] + round_shift(k[i*2] * y0 + k[i*2+1] * y1));
    prev = m_cov;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m_cov[i*4+j] = clamp32(prev[i*4+j] -
                               round_shift(k[i*2] * prev[j] + k[i*2+1] * prev[4+j]));
  endfunction

  // one frame into the model, one track word out
  function automatic track_word_t tracker_step(frame_t f);
    longint zx, zy, px, py, vx, vy;
    int n;
    track_word_t w;
    zx = longint'(f.x) <<< FRAC_POS;
    zy = longint'(f.y) <<< FRAC_POS;
    vx = 0;
    vy = 0;
    if (!m_active) begin
      // idle frame: the point is echoed, a found point seeds the track
      if (f.found) begin
        m_est[0] = zx;
        m_est[1] = zy;
        m_est[2] = 0;
        m_est[3] = 0;
        m_active = 1;
        m_lost   = 0;
      end
      px = zx;
      py = zy;
    end else begin
      tracker_predict();
      if (f.found) begin
        tracker_correct(zx, zy);
        m_lost = 0;
      end else begin
        // miss: the track drops once the count passes max_lost
        n = m_lost + 1;
        if (n > m_max_lost) m_active = 0;
        m_lost = n > 255 ? 255 : n;
      end
      px = m_est[0];
      py = m_est[1];
      vx = m_est[2];
      vy = m_est[3];
    end
    w.px  = kpt_pkg::POS_W'(fit_field(px, kpt_pkg::POS_W));
    w.py  = kpt_pkg::POS_W'(fit_field(py, kpt_pkg::POS_W));
    w.vx  = kpt_pkg::SPD_W'(fit_field(vx, kpt_pkg::SPD_W));
    w.vy  = kpt_pkg::SPD_W'(fit_field(vy, kpt_pkg::SPD_W));
    w.trk = m_active && (m_lost < m_max_lost);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // measurement driver: the model is stepped on every accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_t f;
    if (rst) begin
      meas_ch.valid <= 1'b0;
    end else begin
      if (meas_ch.valid && meas_ch.ready) begin
        f.x     = meas_ch.measured_x;
        f.y     = meas_ch.measured_y;
        f.found = meas_ch.found;
        track_forecast = {track_forecast, tracker_step(f)};
      end
      if (!meas_ch.valid || meas_ch.ready) begin
        if (frame_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          f = frame_queue[0];
          frame_queue.delete(0);
          meas_ch.valid      <= 1'b1;
          meas_ch.measured_x <= f.x;
          meas_ch.measured_y <= f.y;
          meas_ch.found      <= f.found;
        end else begin
          meas_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // track monitor, random back-pressure and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    track_word_t w;
    if (rst) begin
      track_ch.ready <= 1'b0;
      quiet_cycles   <= 0;
    end else begin
      track_ch.ready <= $urandom_range(99) >= stall_pct;
      if (track_ch.valid && track_ch.ready) begin
        if (track_forecast.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          w = track_forecast[0];
          track_forecast.delete(0);
          if (track_ch.position_x !== w.px) report_mismatch("position_x", track_ch.position_x, w.px);
          if (track_ch.position_y !== w.py) report_mismatch("position_y", track_ch.position_y, w.py);
          if (track_ch.speed_x !== w.vx) report_mismatch("speed_x", track_ch.speed_x, w.vx);
          if (track_ch.speed_y !== w.vy) report_mismatch("speed_y", track_ch.speed_y, w.vy);
          if (track_ch.tracking !== w.trk) report_mismatch("tracking", track_ch.tracking, w.trk);
        end
      end
      if ((track_ch.valid && track_ch.ready) || (meas_ch.valid && meas_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIM) begin
        $display("[kalman_point_tracker_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [kpt_pkg::IDX_W-1:0] idx, logic [kpt_pkg::REG_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    // mirror the write in the model; spare indexes are ignored
    case (idx)
      kpt_pkg::REG_PROCESS_NOISE:     m_proc_noise = data[23:0];
      kpt_pkg::REG_MEASUREMENT_NOISE: m_meas_noise = data[23:0];
      kpt_pkg::REG_INIT_COV: begin
        m_init_cov = data;
        reload_cov();
      end
      kpt_pkg::REG_MAX_LOST:          m_max_lost = data[7:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic push_frame(int x, int y, bit fnd);
    frame_t f;
    f.x     = kpt_pkg::MEAS_W'(x < 0 ? 0 : (x > 4095 ? 4095 : x));
    f.y     = kpt_pkg::MEAS_W'(y < 0 ? 0 : (y > 4095 ? 4095 : y));
    f.found = fnd;
    frame_queue = {frame_queue, f};
  endtask

  // mostly plausible tracks with jitter and short dropouts, some noise frames
  task automatic push_random_frames(int count);
    int n, len, x, y, vx, vy, misses;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 80) begin
        x   = $urandom_range(4095);
        y   = $urandom_range(4095);
        vx  = int'($urandom_range(60)) - 30;
        vy  = int'($urandom_range(60)) - 30;
        len = $urandom_range(30, 4);
        for (int i = 0; i < len; i++) begin
          x += vx + int'($urandom_range(6)) - 3;
          y += vy + int'($urandom_range(6)) - 3;
          if ($urandom_range(99) < 12) begin
            // dropout, now and then long enough to lose the track
            misses = ($urandom_range(9) == 0) ? $urandom_range(20, 4) : $urandom_range(2, 1);
            repeat (misses) push_frame(x, y, 0);
            n += misses;
          end else begin
            push_frame(x, y, 1);
            n++;
          end
        end
      end else begin
        push_frame($urandom_range(4095), $urandom_range(4095), $urandom_range(1));
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (frame_queue.size() > 0 || meas_ch.valid || track_forecast.size() > 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    wr_en               = 1'b0;
    wr_index            = '0;
    wr_data             = '0;
    meas_ch.valid       = 1'b0;
    meas_ch.measured_x  = '0;
    meas_ch.measured_y  = '0;
    meas_ch.found       = 1'b0;
    track_ch.ready      = 1'b0;
    err_count           = 0;
    gap_pct             = 0;
    stall_pct           = 0;
    quiet_cycles        = 0;
    tracker_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: idle echo of the extremes, seeding, steady track, loss
    push_frame(0, 0, 0);
    push_frame(4095, 4095, 0);
    push_frame(4095, 0, 1);
    push_frame(4095, 0, 1);
    push_frame(4090, 3, 1);
    push_frame(0, 4095, 1);
    repeat (17) push_frame(0, 0, 0);
    push_frame(2730, 1365, 0);
    push_frame(1365, 2730, 1);
    wait_drained();

    // phase: large process noise, no measurement noise, zero covariance,
    // no misses tolerated
    gap_pct   = 85;
    stall_pct = 0;
    write_reg(kpt_pkg::REG_PROCESS_NOISE, 32'h00ff_ffff);
    write_reg(kpt_pkg::REG_MEASUREMENT_NOISE, 32'h0000_0000);
    write_reg(kpt_pkg::REG_INIT_COV, 32'h0000_0000);
    write_reg(kpt_pkg::REG_MAX_LOST, 32'h0000_0000);
    end_writes();
    push_random_frames(340);
    wait_drained();

    // phase: everything zero, so the innovation is singular
    gap_pct   = 0;
    stall_pct = 85;
    write_reg(kpt_pkg::REG_PROCESS_NOISE, 32'h0000_0000);
    write_reg(kpt_pkg::REG_INIT_COV, 32'h0000_0000);
    write_reg(kpt_pkg::REG_MAX_LOST, 32'h0000_00ff);
    end_writes();
    push_random_frames(340);
    wait_drained();

    // phase: huge covariance and measurement noise, short loss tolerance
    gap_pct   = 7;
    stall_pct = 7;
    write_reg(kpt_pkg::REG_PROCESS_NOISE, $urandom_range(32'h00ff_ffff));
    write_reg(kpt_pkg::REG_MEASUREMENT_NOISE, 32'h00ff_ffff);
    write_reg(kpt_pkg::REG_INIT_COV, 32'hffff_ffff);
    write_reg(kpt_pkg::REG_MAX_LOST, 32'd3);
    end_writes();
    push_random_frames(340);
    wait_drained();

    // phase: random settings, and writes to spare indexes that must be ignored
    gap_pct   = 85;
    stall_pct = 85;
    write_reg(kpt_pkg::REG_PROCESS_NOISE, $urandom());
    write_reg(kpt_pkg::REG_MEASUREMENT_NOISE, $urandom());
    write_reg(kpt_pkg::REG_INIT_COV, $urandom());
    write_reg(kpt_pkg::REG_MAX_LOST, $urandom());
    for (int i = 0; i < 4; i++)
      write_reg(FIRST_SPARE_IDX + kpt_pkg::IDX_W'(i), $urandom());
    end_writes();
    push_random_frames(340);
    wait_drained();

    // phase: back to the defaults, no idling
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(kpt_pkg::REG_PROCESS_NOISE, 32'(kpt_pkg::PROCESS_NOISE_RST));
    write_reg(kpt_pkg::REG_MEASUREMENT_NOISE, 32'(kpt_pkg::MEASUREMENT_NOISE_RST));
    write_reg(kpt_pkg::REG_INIT_COV, kpt_pkg::INIT_COV_RST);
    write_reg(kpt_pkg::REG_MAX_LOST, 32'(kpt_pkg::MAX_LOST_RST));
    end_writes();
    push_random_frames(300);
    wait_drained();

    if (err_count == 0) begin
      $display("[kalman_point_tracker_core] OK");
    end else begin
      $display("[kalman_point_tracker_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
